### rtl/dual_motor_speed_to_pwm_unit_macros.svh
// Assertion macros shared by the motor PWM unit RTL.
`ifndef DUAL_MOTOR_SPEED_TO_PWM_UNIT_MACROS_SVH
`define DUAL_MOTOR_SPEED_TO_PWM_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define DMSP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmsp assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define DMSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmsp assertion failed");
`else
`define DMSP_ASSERT_NOW(label, clk, rst, ante, cons)
`define DMSP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/dmsp_pkg.sv
// Shared constants and control/status types for the motor PWM unit.
`timescale 1ns / 1ps
`default_nettype none

package dmsp_pkg;

  // Field widths
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned WRAP_W    = 16;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  // Product of a percent and the wrap value
  localparam int unsigned PROD_W    = PCT_W + WRAP_W;

  // Reciprocal of 100 for the clamp limit: floor(p / 100) equals
  // (p * LIM_RECIP) >> LIM_SHIFT for every product p below 2**PROD_W
  localparam int unsigned LIM_RECIP_W = 24;
  localparam int unsigned LIM_SHIFT   = 30;
  localparam int unsigned LIM_PROD_W  = PROD_W + LIM_RECIP_W;
  localparam logic [LIM_RECIP_W-1:0] LIM_RECIP = 24'd10737419;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_BRAKE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PCT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_TOP  = 2'd3;

  // Register reset values
  localparam logic [PCT_W-1:0]  MIN_PCT_RST  = 7'd10;
  localparam logic [PCT_W-1:0]  MAX_PCT_RST  = 7'd100;
  localparam logic [WRAP_W-1:0] WRAP_TOP_RST = 16'd1000;

  // Speed saturation and percent scale
  localparam logic [PCT_W-1:0] FULL_PCT = 7'd100;

  // Operation codes
  localparam logic OP_SPEED = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic ready;      // take an input item this cycle
    logic chan;       // 0 left, 1 right
    logic mul_en;     // register the product
    logic mul_tick;   // product is max_pct * wrap top
    logic limit_en;   // register the clamp limit
    logic div_start;  // launch the divider
    logic store;      // write pending duty and direction of chan
    logic tick_apply; // count the tick and apply pending duties
    logic out_load;   // capture the result item
  } dmsp_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cmd_valid;
    logic cmd_op;
    logic div_done;
    logic out_stall;
  } dmsp_sts_t;

endpackage

`default_nettype wire

### rtl/dmsp_cmd_if.sv
// Input item channel: operation and the two speed setpoints.
`timescale 1ns / 1ps
`default_nettype none

interface dmsp_cmd_if import dmsp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [SPEED_W-1:0] speed_l;
  logic signed [SPEED_W-1:0] speed_r;

  modport source (output valid, output op, output speed_l, output speed_r,
                  input ready);
  modport sink (input valid, input op, input speed_l, input speed_r,
                output ready);
endinterface

`default_nettype wire

### rtl/dmsp_res_if.sv
// Result item channel: directions, applied levels, pending flag, tick count.
`timescale 1ns / 1ps
`default_nettype none

interface dmsp_res_if import dmsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIR_W-1:0]  left_dir;
  logic [DIR_W-1:0]  right_dir;
  logic [WRAP_W-1:0] left_level;
  logic [WRAP_W-1:0] right_level;
  logic              update_pending;
  logic [TICK_W-1:0] tick_count;

  modport source (output valid, output left_dir, output right_dir, output left_level,
                  output right_level, output update_pending, output tick_count,
                  input ready);
  modport sink (input valid, input left_dir, input right_dir, input left_level,
                input right_level, input update_pending, input tick_count,
                output ready);
endinterface

`default_nettype wire

### rtl/dmsp_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none

interface dmsp_cfg_if import dmsp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/dmsp_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module dmsp_div import dmsp_pkg::*; #(
  parameter int unsigned DW = PROD_W,
  parameter int unsigned VW = PCT_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [DW-1:0] quo;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;

  logic [VW:0] rem_sh;
  logic [VW:0] diff;
  logic        ge;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh = {rem, quo[DW-1]};
    diff   = rem_sh - {1'b0, dvs};
    ge     = (rem_sh >= {1'b0, dvs});
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Hold operands, advance remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
      quo <= {quo[DW-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

### rtl/dmsp_datapath.sv
// Datapath: config registers, channel mapping, multiplier, divider, state, result register.
`timescale 1ns / 1ps
`default_nettype none

module dmsp_datapath import dmsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  dmsp_cmd_if.sink  cmd,
  dmsp_res_if.source res,
  dmsp_cfg_if.sink  cfg,
  input  dmsp_ctl_t ctl,
  output dmsp_sts_t sts
);

  // Configuration registers
  logic [PCT_W-1:0]  min_left;
  logic [PCT_W-1:0]  min_right;
  logic [PCT_W-1:0]  max_pct;
  logic [WRAP_W-1:0] wrap_top;

  // Latched speeds
  logic signed [SPEED_W-1:0] speed_l_q;
  logic signed [SPEED_W-1:0] speed_r_q;

  // Block state
  logic [WRAP_W-1:0] pending_left;
  logic [WRAP_W-1:0] pending_right;
  logic              pending_flag;
  logic [WRAP_W-1:0] applied_left;
  logic [WRAP_W-1:0] applied_right;
  logic [DIR_W-1:0]  left_dir_q;
  logic [DIR_W-1:0]  right_dir_q;
  logic [TICK_W-1:0] ticks;

  // Arithmetic
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] quo;
  logic              div_done;

  // Clamp limit terms
  logic [LIM_PROD_W-1:0]           lim_prod;
  logic [LIM_PROD_W-LIM_SHIFT-1:0] lim_quo;
  logic [WRAP_W-1:0]               limit;

  // Channel mapping terms
  logic signed [SPEED_W-1:0] spd;
  logic [PCT_W-1:0]          minp;
  logic [SPEED_W:0]          absv;
  logic                      neg;
  logic                      dead;
  logic [PCT_W-1:0]          mag;
  logic                      below_min;
  logic                      empty_range;
  logic [DIR_W-1:0]          dir;
  logic [PCT_W-1:0]          mul_a;
  logic [PCT_W-1:0]          div_den;
  logic [WRAP_W-1:0]         duty;
  logic                      res_valid;

  assign cfg.ready = 1'b1;
  assign cmd.ready = ctl.ready;

  assign sts.cmd_valid = cmd.valid;
  assign sts.cmd_op    = cmd.op;
  assign sts.div_done  = div_done;
  assign sts.out_stall = res_valid && !res.ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_left  <= MIN_PCT_RST;
      min_right <= MIN_PCT_RST;
      max_pct   <= MAX_PCT_RST;
      wrap_top  <= WRAP_TOP_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MIN_LEFT:  min_left  <= cfg.data[PCT_W-1:0];
        REG_MIN_RIGHT: min_right <= cfg.data[PCT_W-1:0];
        REG_MAX_PCT:   max_pct   <= cfg.data[PCT_W-1:0];
        REG_WRAP_TOP:  wrap_top  <= cfg.data[WRAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch speeds on accept
  always_ff @(posedge clk) begin
    if (cmd.valid && ctl.ready) begin
      speed_l_q <= cmd.speed_l;
      speed_r_q <= cmd.speed_r;
    end
  end

  // Dead zone, saturation and direction of the selected channel
  always_comb begin
    spd         = ctl.chan ? speed_r_q : speed_l_q;
    minp        = ctl.chan ? min_right : min_left;
    neg         = spd[SPEED_W-1];
    absv        = neg ? ((SPEED_W+1)'(0) - {spd[SPEED_W-1], spd}) : {1'b0, spd};
    dead        = (absv < {{(SPEED_W+1-PCT_W){1'b0}}, minp}) || (spd == '0);
    mag         = (absv > (SPEED_W+1)'(FULL_PCT)) ? FULL_PCT : absv[PCT_W-1:0];
    below_min   = mag < minp;
    empty_range = max_pct <= minp;
    dir         = dead ? DIR_BRAKE : (neg ? DIR_REV : DIR_FWD);
    mul_a       = ctl.mul_tick ? max_pct : (mag - minp);
    div_den     = max_pct - minp;
  end

  // Pick the duty to hold pending
  always_comb begin
    if (dead || below_min) begin
      duty = '0;
    end else if (empty_range) begin
      duty = wrap_top;
    end else if (quo > {{PCT_W{1'b0}}, wrap_top}) begin
      duty = wrap_top;
    end else begin
      duty = quo[WRAP_W-1:0];
    end
  end

  // Register the product
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= {{WRAP_W{1'b0}}, mul_a} * {{PCT_W{1'b0}}, wrap_top};
    end
  end

  // Divide the product by 100 through the reciprocal
  always_comb begin
    lim_prod = {{LIM_RECIP_W{1'b0}}, prod} * {{PROD_W{1'b0}}, LIM_RECIP};
    lim_quo  = (LIM_PROD_W-LIM_SHIFT)'(lim_prod >> LIM_SHIFT);
  end

  // Register the clamp limit, saturated to the level width
  always_ff @(posedge clk) begin
    if (ctl.limit_en) begin
      limit <= (lim_quo > (LIM_PROD_W-LIM_SHIFT)'({WRAP_W{1'b1}})) ?
               {WRAP_W{1'b1}} : lim_quo[WRAP_W-1:0];
    end
  end

  dmsp_div #(
    .DW (PROD_W),
    .VW (PCT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (prod),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (quo)
  );

  // Update pending duties, directions, applied levels and tick count
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_left  <= '0;
      pending_right <= '0;
      pending_flag  <= 1'b0;
      applied_left  <= '0;
      applied_right <= '0;
      left_dir_q    <= DIR_BRAKE;
      right_dir_q   <= DIR_BRAKE;
      ticks         <= '0;
    end else begin
      if (ctl.store) begin
        if (ctl.chan) begin
          pending_right <= duty;
          right_dir_q   <= dir;
          pending_flag  <= 1'b1;
        end else begin
          pending_left <= duty;
          left_dir_q   <= dir;
        end
      end
      if (ctl.tick_apply) begin
        ticks <= ticks + TICK_W'(1);
        if (pending_flag) begin
          applied_left  <= (pending_left > limit) ? limit : pending_left;
          applied_right <= (pending_right > limit) ? limit : pending_right;
          pending_flag  <= 1'b0;
        end
      end
    end
  end

  // Result valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.out_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Capture the result item
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      res.left_dir       <= left_dir_q;
      res.right_dir      <= right_dir_q;
      res.left_level     <= applied_left;
      res.right_level    <= applied_right;
      res.update_pending <= pending_flag;
      res.tick_count     <= ticks;
    end
  end

  assign res.valid = res_valid;

endmodule

`default_nettype wire

### rtl/dmsp_ctrl.sv
// Controller: sequences the multiply, divide, store, limit and tick-apply steps of one item.
`timescale 1ns / 1ps
`default_nettype none

`include "dual_motor_speed_to_pwm_unit_macros.svh"

module dmsp_ctrl import dmsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  dmsp_sts_t sts,
  output dmsp_ctl_t ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_STORE  = 3'd4;
  localparam logic [2:0] S_TAPPLY = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;
  localparam logic [2:0] S_LIMIT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       tick;
  logic       tick_next;
  logic       chan;
  logic       chan_next;

  // Next state and commands
  always_comb begin
    state_next     = state;
    tick_next      = tick;
    chan_next      = chan;
    ctl            = '0;
    ctl.chan       = chan;
    ctl.mul_tick   = tick;
    case (state)
      S_IDLE: begin
        ctl.ready = 1'b1;
        if (sts.cmd_valid) begin
          tick_next  = (sts.cmd_op == OP_TICK);
          chan_next  = 1'b0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        ctl.mul_en = 1'b1;
        state_next = tick ? S_LIMIT : S_DIV;
      end
      S_LIMIT: begin
        ctl.limit_en = 1'b1;
        state_next   = S_TAPPLY;
      end
      S_DIV: begin
        ctl.div_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (sts.div_done) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        ctl.store = 1'b1;
        if (chan) begin
          state_next = S_FINISH;
        end else begin
          chan_next  = 1'b1;
          state_next = S_MUL;
        end
      end
      S_TAPPLY: begin
        ctl.tick_apply = 1'b1;
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_stall) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tick  <= 1'b0;
      chan  <= 1'b0;
    end else begin
      state <= state_next;
      tick  <= tick_next;
      chan  <= chan_next;
    end
  end

  // Never overwrite a result that waits to be taken
  `DMSP_ASSERT_NOW(a_load_free, clk, rst, ctl.out_load, !sts.out_stall)
  // Divider finishes only while the controller waits for it
  `DMSP_ASSERT_NOW(a_done_in_wait, clk, rst, sts.div_done, state == S_WAIT)
  // Storing the right channel closes a speed command
  `DMSP_ASSERT_NEXT(a_right_last, clk, rst, ctl.store && chan, state == S_FINISH)
  // A tick never writes pending duties
  `DMSP_ASSERT_NOW(a_tick_no_store, clk, rst, ctl.store, !tick)

endmodule

`default_nettype wire

### rtl/dual_motor_speed_to_pwm_unit.sv
// Dual H-bridge motor speed-to-PWM unit, top level.
// A speed command (op 0) sets the two direction outputs at once and maps each speed
// through its dead zone to a duty held pending; a wrap tick (op 1) counts and applies the
// pending duties, clamped to max_pct * wrap / 100. Every item returns one result
// with the state after it. Items are worked one at a time: a speed command runs the
// bit-serial 23-step divider once per motor channel, each run with its multiply,
// launch, wait and store steps. A tick runs its multiply, limit and apply steps: its
// clamp limit comes from one product and one reciprocal multiply. The result sits in an
// output register, so the next item is taken while it waits; a result still waiting
// holds the following one in its last cycle. Configuration writes are accepted every
// cycle and must only be issued while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module dual_motor_speed_to_pwm_unit import dmsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dmsp_cmd_if.sink   cmd,
  dmsp_res_if.source res,
  dmsp_cfg_if.sink   cfg
);

  dmsp_ctl_t ctl;
  dmsp_sts_t sts;

  dmsp_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  dmsp_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res),
    .cfg (cfg),
    .ctl (ctl),
    .sts (sts)
  );

endmodule

`default_nettype wire
